// ----- src/vector_magnitude_isqrt_3d_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vector magnitude block
// Implication checks, sampled on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_ISQRT_3D_MACROS_SVH
`define VECTOR_MAGNITUDE_ISQRT_3D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define VMI3_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VMI3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vmi3_pkg.sv -----
// ----------------------------------------------------------------------------
// vmi3_pkg
// Shared widths, sequencer states and control structs of the magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmi3_pkg;

    // field and datapath widths
    localparam int FIELD_W = 31;            // one signed component
    localparam int SUM_W   = 62;            // sum of three squares, below 2^62
    localparam int ROOT_W  = 63;            // working root register
    localparam int CNT_W   = 5;             // step counter

    // sequencer step limits
    localparam int SQ_LAST  = 4;            // square phase runs steps 0..4
    localparam int SQ_MUL_LAST = 2;         // last component squared
    localparam int SQ_ACC_LAST = 3;         // last product accumulated
    localparam int RT_LAST  = 31;           // root phase runs 32 bit-pair steps

    // stream packing
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } t_state;

    // controls for the squaring accumulator
    typedef struct packed {
        logic       load;       // capture components, clear accumulator
        logic       mul_en;     // square selected component
        logic [1:0] sel;        // component select: 0 x, 1 y, 2 z
        logic       acc_en;     // add registered product
    } t_sq_ctl;

    // controls for the root unit
    typedef struct packed {
        logic init;             // load remainder, clear root, set trial bit
        logic step;             // one bit-pair iteration
    } t_rt_ctl;

endpackage

`default_nettype wire

// ----- src/vmi3_sumsq.sv -----
// ----------------------------------------------------------------------------
// vmi3_sumsq
// Sum of squares through one shared 31 x 31 multiplier, one component a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmi3_sumsq (
    input  wire logic                              i_clk,
    input  wire vmi3_pkg::t_sq_ctl                 i_ctl,
    input  wire logic signed [vmi3_pkg::FIELD_W-1:0] i_field_x,
    input  wire logic signed [vmi3_pkg::FIELD_W-1:0] i_field_y,
    input  wire logic signed [vmi3_pkg::FIELD_W-1:0] i_field_z,
    output logic [vmi3_pkg::SUM_W-1:0]             o_sum
);

    localparam int FW = vmi3_pkg::FIELD_W;
    localparam int SW = vmi3_pkg::SUM_W;

    // absolute value; the most negative code maps to 2^30, which still fits
    function automatic logic [FW-1:0] abs_field(input logic signed [FW-1:0] v);
        logic [FW-1:0] u;
        u = v;
        abs_field = v[FW-1] ? (~u + FW'(1)) : u;
    endfunction

    logic [FW-1:0] r_ax, r_ay, r_az;
    logic [FW-1:0] w_opnd;
    logic [SW-1:0] r_prod;
    logic [SW-1:0] r_acc;

    // component capture on transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ax <= abs_field(i_field_x);
            r_ay <= abs_field(i_field_y);
            r_az <= abs_field(i_field_z);
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (i_ctl.sel)
            2'd0:    w_opnd = r_ax;
            2'd1:    w_opnd = r_ay;
            default: w_opnd = r_az;
        endcase
    end

    // square, registered before the add
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= SW'(w_opnd) * SW'(w_opnd);
        end
    end

    // accumulate; three squares of at most 2^60 stay below 2^62
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_sum = r_acc;

endmodule

`default_nettype wire

// ----- src/vmi3_isqrt.sv -----
// ----------------------------------------------------------------------------
// vmi3_isqrt
// Floor square root, bit-pair method, one trial subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmi3_isqrt (
    input  wire logic                          i_clk,
    input  wire vmi3_pkg::t_rt_ctl             i_ctl,
    input  wire logic [vmi3_pkg::SUM_W-1:0]    i_sum,
    output logic [vmi3_pkg::FIELD_W-1:0]       o_root
);

    localparam int SW = vmi3_pkg::SUM_W;
    localparam int RW = vmi3_pkg::ROOT_W;

    logic [SW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [RW-1:0] r_trial;
    logic [RW:0]   w_cand;
    logic          w_fit;
    logic [RW:0]   w_root_up;

    // shared unit: root + trial, compare against remainder
    assign w_cand    = {1'b0, r_root} + {1'b0, r_trial};
    assign w_fit     = ({(RW + 1 - SW)'(0), r_rem} >= w_cand);
    assign w_root_up = {2'b00, r_root[RW-1:1]} + {1'b0, r_trial};

    // iteration registers; trial starts at bit 62 and falls two bits a step
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_rem   <= i_sum;
            r_root  <= '0;
            r_trial <= {1'b1, (RW - 1)'(0)};
        end else if (i_ctl.step) begin
            if (w_fit) begin
                r_rem  <= r_rem - w_cand[SW-1:0];
                r_root <= w_root_up[RW-1:0];
            end else begin
                r_root <= {1'b0, r_root[RW-1:1]};
            end
            r_trial <= {2'b00, r_trial[RW-1:2]};
        end
    end

    assign o_root = r_root[vmi3_pkg::FIELD_W-1:0];

endmodule

`default_nettype wire

// ----- src/vmi3_ctrl.sv -----
// ----------------------------------------------------------------------------
// vmi3_ctrl
// Sequencer: accept, square phase, root phase, hand-off to output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmi3_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_free,
    output logic                o_in_ready,
    output logic                o_load_out,
    output vmi3_pkg::t_sq_ctl   o_sq_ctl,
    output vmi3_pkg::t_rt_ctl   o_rt_ctl
);

    localparam int CW = vmi3_pkg::CNT_W;

    vmi3_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmi3_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vmi3_pkg::ST_IDLE:   if (i_in_valid) n_state = vmi3_pkg::ST_SQUARE;
            vmi3_pkg::ST_SQUARE: if (r_cnt == CW'(vmi3_pkg::SQ_LAST))
                                     n_state = vmi3_pkg::ST_ROOT;
            vmi3_pkg::ST_ROOT:   if (r_cnt == CW'(vmi3_pkg::RT_LAST))
                                     n_state = vmi3_pkg::ST_DONE;
            vmi3_pkg::ST_DONE:   if (i_out_free) n_state = vmi3_pkg::ST_IDLE;
            default:             n_state = vmi3_pkg::ST_IDLE;
        endcase
    end

    // step counter restarts on each phase change
    always_comb begin
        if ((n_state != r_state) || (r_state == vmi3_pkg::ST_IDLE) ||
            (r_state == vmi3_pkg::ST_DONE)) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_load_out      = 1'b0;
        o_sq_ctl        = '0;
        o_rt_ctl        = '0;
        o_sq_ctl.sel    = r_cnt[1:0];
        case (r_state)
            vmi3_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_sq_ctl.load = i_in_valid;
            end
            vmi3_pkg::ST_SQUARE: begin
                o_sq_ctl.mul_en = (r_cnt <= CW'(vmi3_pkg::SQ_MUL_LAST));
                o_sq_ctl.acc_en = (r_cnt != '0) &&
                                  (r_cnt <= CW'(vmi3_pkg::SQ_ACC_LAST));
                o_rt_ctl.init   = (r_cnt == CW'(vmi3_pkg::SQ_LAST));
            end
            vmi3_pkg::ST_ROOT: begin
                o_rt_ctl.step = 1'b1;
            end
            vmi3_pkg::ST_DONE: begin
                o_load_out = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/vector_magnitude_isqrt_3d.sv -----
// ----------------------------------------------------------------------------
// vector_magnitude_isqrt_3d
// Floor of the Euclidean length of a three-component field vector.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one vector per transaction; tdata carries x, y, z as
//   31-bit two's complement values. Master stream returns one 31-bit
//   magnitude per input vector, floor(sqrt(x^2 + y^2 + z^2)).
//   Sequence: the accepted vector is squared and accumulated in the square
//   phase, its root is built in the root phase, and the result is then
//   handed to the output register; only then is the next vector taken.
//   The square phase is paced by the single shared 31 x 31 multiplier,
//   the root phase by the one bit-pair subtract/compare unit, one result
//   bit per cycle.
//   tready on the slave side is high only while the sequencer is idle.
//   The result sits in an output register; a new vector is taken while it
//   waits. If the receiver still stalls when the next result is finished,
//   the sequencer holds that result and does not accept a further vector.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   the output valid; the datapath and output data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vector_magnitude_isqrt_3d_macros.svh"

module vector_magnitude_isqrt_3d (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // fields from bit 0: field_x[30:0], field_y[61:31], field_z[92:62], zero pad
    input  wire logic [vmi3_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // fields from bit 0: magnitude[30:0], zero pad
    output logic [vmi3_pkg::M_TDATA_W-1:0]          o_m_axis_tdata
);

    localparam int FW = vmi3_pkg::FIELD_W;

    logic signed [FW-1:0] w_field_x, w_field_y, w_field_z;
    vmi3_pkg::t_sq_ctl    w_sq_ctl;
    vmi3_pkg::t_rt_ctl    w_rt_ctl;
    logic [vmi3_pkg::SUM_W-1:0] w_sum;
    logic [FW-1:0]        w_root;
    logic                 w_load_out;
    logic                 w_out_free;
    logic                 w_in_acc;
    logic                 r_out_valid;
    logic [FW-1:0]        r_out_data;

    // unpack input transaction
    assign w_field_x = i_s_axis_tdata[FW-1:0];
    assign w_field_y = i_s_axis_tdata[2*FW-1:FW];
    assign w_field_z = i_s_axis_tdata[3*FW-1:2*FW];

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    vmi3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (o_s_axis_tready),
        .o_load_out (w_load_out),
        .o_sq_ctl   (w_sq_ctl),
        .o_rt_ctl   (w_rt_ctl)
    );

    vmi3_sumsq u_sumsq (
        .i_clk     (i_clk),
        .i_ctl     (w_sq_ctl),
        .i_field_x (w_field_x),
        .i_field_y (w_field_y),
        .i_field_z (w_field_z),
        .o_sum     (w_sum)
    );

    vmi3_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_ctl  (w_rt_ctl),
        .i_sum  (w_sum),
        .o_root (w_root)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_root;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(vmi3_pkg::M_TDATA_W - FW)'(0), r_out_data};

    // checks
    `VMI3_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_s_axis_tready, "busy miss")
    `VMI3_ASSERT_SAME(a_load_only_free, i_clk, i_rst_n, w_load_out, w_out_free, "result overrun")
    `VMI3_ASSERT_NEXT(a_valid_after_load, i_clk, i_rst_n, w_load_out, o_m_axis_tvalid, "valid miss")

endmodule

`default_nettype wire

// ----- test/tb_vector_magnitude_isqrt_3d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_magnitude_isqrt_3d
// Self-checking bench for the 3-D field vector magnitude block. A queue of
// vectors (directed corners first, then random mixes of full-range, small,
// extreme and exact-root vectors) feeds a stream driver. A monitor checks
// each returned magnitude against a local floor-sqrt predictor. Both sides
// idle in random bursts, and the receiver holds off once for a long stretch
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------

module tb_vector_magnitude_isqrt_3d;

    localparam int FIELD_W   = vmi3_pkg::FIELD_W;
    localparam int S_TDATA_W = vmi3_pkg::S_TDATA_W;
    localparam int M_TDATA_W = vmi3_pkg::M_TDATA_W;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct {
        t_field x;
        t_field y;
        t_field z;
    } t_field_vec;

    localparam t_field F_MAX       = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam t_field F_MIN       = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     RAND_ITEMS  = 1750;
    localparam int     CALM_TAIL   = 150;   // last items sent with no idling
    localparam int     HOLD_AFTER  = 100;   // results seen before the long hold
    localparam int     HOLD_CYCLES = 500;
    localparam int     SETTLE      = 60;    // wait after the queues drain

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;

    t_field_vec             pending_vecs[$];
    t_field                 expected_mags[$];
    int                     n_errors    = 0;
    int                     n_results   = 0;
    int                     cycles      = 0;
    int                     rx_hold     = 0;
    logic                   hold_done   = 1'b0;
    logic                   tail_calm   = 1'b0;

    vector_magnitude_isqrt_3d u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // x[30:0], y[61:31], z[92:62], zero pad
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)     // magnitude[30:0], zero pad
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // Expected magnitude: abs of each component, sum of squares, then the
    // root built one bit at a time from the top, keeping a bit while the
    // square of the candidate still fits under the sum.
    function automatic t_field vec_len_floor(t_field fx, t_field fy, t_field fz);
        logic [63:0] mx, my, mz, sq_sum, cand;
        t_field      root;
        mx = fx[FIELD_W-1] ? (64'd1 << FIELD_W) - 64'(fx) : 64'(fx);
        my = fy[FIELD_W-1] ? (64'd1 << FIELD_W) - 64'(fy) : 64'(fy);
        mz = fz[FIELD_W-1] ? (64'd1 << FIELD_W) - 64'(fz) : 64'(fz);
        sq_sum = mx * mx + my * my + mz * mz;
        root = '0;
        for (int b = FIELD_W - 1; b >= 0; b--) begin
            cand = 64'(root | (t_field'(1) << b));
            if (cand * cand <= sq_sum)
                root[b] = 1'b1;
        end
        return root;
    endfunction

    function automatic void add_vec(t_field fx, t_field fy, t_field fz);
        t_field_vec v;
        v.x = fx;
        v.y = fy;
        v.z = fz;
        pending_vecs.push_back(v);
    endfunction

    // One random component from a mix of value classes
    function automatic t_field rand_field();
        t_field v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = t_field'($urandom());
            4:          v = t_field'(int'($urandom_range(0, 200)) - 100);
            5: begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = t_field'(1);
                    2:       v = '1;
                    3:       v = F_MAX;
                    4:       v = F_MIN;
                    default: v = F_MIN + t_field'(1);
                endcase
            end
            6: begin
                v = t_field'(1) << $urandom_range(0, FIELD_W - 2);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                v = t_field'($urandom() >> $urandom_range(1, 31));
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // Vector with an exact integer length (scaled Pythagorean quadruple),
    // one component nudged by one now and then to land just off the square.
    function automatic void add_exact_vec();
        int a, b, c, k;
        t_field fx, fy, fz;
        case ($urandom_range(0, 3))
            0:       begin a = 1; b = 2; c = 2; end
            1:       begin a = 2; b = 3; c = 6; end
            2:       begin a = 1; b = 4; c = 8; end
            default: begin a = 4; b = 4; c = 7; end
        endcase
        k  = $urandom_range(1, 1 << $urandom_range(0, 26));
        fx = t_field'(a * k);
        fy = t_field'(b * k);
        fz = t_field'(c * k);
        if ($urandom_range(0, 1)) fx = -fx;
        if ($urandom_range(0, 1)) fy = -fy;
        if ($urandom_range(0, 1)) fz = -fz;
        case ($urandom_range(0, 3))
            0: fx = fx - t_field'(1);
            1: fz = fz + t_field'(1);
            default: ;
        endcase
        add_vec(fx, fy, fz);
    endfunction

    // Stimulus, reset and end of run
    initial begin
        // zero vector, unit components of both signs
        add_vec('0, '0, '0);
        add_vec(t_field'(1), '0, '0);
        add_vec('1, '0, '0);
        add_vec('0, '1, '0);
        add_vec('0, '0, t_field'(1));
        add_vec('1, '1, '1);
        // single-axis extremes, most negative has a representable magnitude
        add_vec(F_MAX, '0, '0);
        add_vec(F_MIN, '0, '0);
        add_vec('0, F_MIN, '0);
        add_vec('0, '0, F_MAX);
        add_vec(F_MIN + t_field'(1), '0, '0);
        // largest sums
        add_vec(F_MAX, F_MAX, F_MAX);
        add_vec(F_MIN, F_MIN, F_MIN);
        add_vec(F_MIN, F_MAX, F_MIN);
        // small exact lengths and their neighbours
        add_vec(t_field'(3), t_field'(4), '0);
        add_vec(-t_field'(2), t_field'(3), -t_field'(6));
        add_vec(t_field'(1), t_field'(1), t_field'(1));
        add_vec(t_field'(2), t_field'(2), t_field'(1));
        add_vec(t_field'(2), t_field'(2), t_field'(0));
        add_vec(t_field'(1 << 26), t_field'(2 << 26), -t_field'(2 << 26));
        add_vec(t_field'(65535), t_field'(65535), t_field'(65535));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 15)
                add_exact_vec();
            else
                add_vec(rand_field(), rand_field(), rand_field());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_vecs.size() != 0 || s_tvalid || expected_mags.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_errors == 0)
            $display("tb_vector_magnitude_isqrt_3d: done, clean");
        else
            $display("tb_vector_magnitude_isqrt_3d: done, errors");
        $finish;
    end

    // Input driver: predicts on each accepted transaction, then either idles
    // for a burst or presents the next queued vector.
    always @(posedge i_clk) begin : p_drive
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        t_field_vec           v;
        int                   tx_gap;
        int                   tx_idle_pct;
        if (!i_rst_n) begin
            s_tvalid    <= 1'b0;
            tx_gap      = 0;
            tx_idle_pct = 20;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                expected_mags.push_back(vec_len_floor(
                    s_tdata[FIELD_W-1:0],
                    s_tdata[2*FIELD_W-1:FIELD_W],
                    s_tdata[3*FIELD_W-1:2*FIELD_W]));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap != 0) begin
                    tx_gap = tx_gap - 1;
                end else if (pending_vecs.size() != 0) begin
                    v         = pending_vecs.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = {{(S_TDATA_W - 3*FIELD_W){1'b0}}, v.z, v.y, v.x};
                    // vary the idle rate, including stretches with none
                    if ($urandom_range(0, 63) == 0)
                        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                      $urandom_range(5, 50);
                    if (!tail_calm && $urandom_range(0, 99) < tx_idle_pct)
                        tx_gap = $urandom_range(1, 7);
                end
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_data;
            tail_calm <= (pending_vecs.size() < CALM_TAIL);
        end
    end

    // Long receiver hold-off, once, after the first batch of results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold   <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            rx_hold   <= HOLD_CYCLES;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Output monitor: checks each accepted result and drives tready
    always @(posedge i_clk) begin : p_watch
        t_field want;
        logic   nxt_ready;
        int     rx_gap;
        int     rx_idle_pct;
        if (!i_rst_n) begin
            m_tready    <= 1'b0;
            rx_gap      = 0;
            rx_idle_pct = 20;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results <= n_results + 1;
                if (expected_mags.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: magnitude %0d returned, expected none",
                             $time, m_tdata[FIELD_W-1:0]);
                end else begin
                    want = expected_mags.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== want) begin
                        n_errors++;
                        $display("%0t ns: magnitude mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata[FIELD_W-1:0]);
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                  $urandom_range(5, 50);
            end
            if (rx_hold != 0) begin
                nxt_ready = 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap    = rx_gap - 1;
                nxt_ready = 1'b0;
            end else if (!tail_calm && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap    = $urandom_range(0, 6);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_vector_magnitude_isqrt_3d: done, errors");
            $finish;
        end
    end

endmodule
